// ===== src/hpa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hpa_pkg: shared types and constants
// Fixed-point widths, pipeline depths and the offset bundle of the
// HSL pixel adjuster.
// ---------------------------------------------------------------------------
package hpa_pkg;

   // Q0.16 fractions
   localparam int FracBits = 16;

   // Divider: numerator and divisor width, quotient holds 1.0 (17 bits)
   localparam int DivWidth        = 11;
   localparam int QuoWidth        = FracBits + 1;
   localparam int DivFracPerStage = 4;
   localparam int DivStages       = 1 + FracBits / DivFracPerStage;

   // Back conversion stages: product, q/p and bands, band product, output
   localparam int BackStages = 4;

   // Offsets: signed Q0.16 with room for +-1.42
   localparam int OffWidth = 18;

   localparam logic [FracBits-1:0] CompMax = 16'd64880;
   localparam logic [FracBits-1:0] Third   = 16'd21845;

   typedef enum logic [1:0] {
      CSR_HUE = 2'd0,
      CSR_SAT = 2'd1,
      CSR_LIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [OffWidth-1:0] hue;
      logic signed [OffWidth-1:0] sat;
      logic signed [OffWidth-1:0] lit;
   } offsets_type;

endpackage

// ===== src/hpa_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hpa_if: pixel channels
// Valid/ready channels for the source pixel and the adjusted pixel.
// ---------------------------------------------------------------------------
interface hpa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface hpa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== src/hsl_pixel_adjust.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl_pixel_adjust: hue / saturation / lightness adjust of RGB pixels
// Converts each pixel to HSL in Q0.16, adds the offset registers, clamps to
// 0 .. 0.99 and converts back to RGB.
// ---------------------------------------------------------------------------
// The block takes one pixel every clock and returns each adjusted pixel
// through twelve register stages, in order, when the output side keeps
// up. The whole pipeline moves as one: while an adjusted pixel waits at
// the output, every stage holds, and the input side is ready again as
// soon as that item is taken. The two fraction dividers (hue and
// saturation) take five stages: they resolve the integer bit in their
// first stage and four quotient bits in each stage after it; the rest is
// one stage of input, one of max/min setup, one of offset and clamp, and
// four of back conversion. Offsets are written in degrees
// (hue_offset, index 0) and percent (saturation_offset, index 1;
// lightness_offset, index 2); each write is scaled to Q0.16 in the same
// cycle, so a pixel may follow the write at once. There is no clearing
// pass: the block is ready in the cycle after reset drops.
// ---------------------------------------------------------------------------
module hsl_pixel_adjust (
   input  logic           clock,
   input  logic           reset,
   hpa_req_if.sink        req_chan,
   hpa_rsp_if.source      rsp_chan,
   input  logic           csr_write_en,
   input  logic [1:0]     csr_index,
   input  logic [9:0]     csr_data
);

   localparam int StB       = 1;
   localparam int StC       = StB + hpa_pkg::DivStages + 1;
   localparam int NumStages = StC + 1 + hpa_pkg::BackStages;

   hpa_pkg::offsets_type offsets;

   // hold the whole pipe while the output item waits
   logic                 adv;
   logic [NumStages-1:0] vld_ff, vld_in;

   assign adv            = !vld_ff[NumStages-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign vld_in         = {vld_ff[NumStages-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   hpa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .offsets      (offsets)
   );

   // stage A: capture the pixel
   logic [7:0] r_ff, g_ff, b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff <= req_chan.red_in;
         g_ff <= req_chan.green_in;
         b_ff <= req_chan.blue_in;
      end
   end

   // stage B: max, min, lightness and the two divisions to set up
   logic [7:0]                   mx, mn, dlt;
   logic [8:0]                   sum, sden;
   logic [hpa_pkg::DivWidth-1:0] six_d, hnum;

   always_comb begin
      mx = r_ff;
      mn = r_ff;
      if (g_ff > mx) mx = g_ff;
      if (b_ff > mx) mx = b_ff;
      if (g_ff < mn) mn = g_ff;
      if (b_ff < mn) mn = b_ff;
      dlt   = mx - mn;
      sum   = {1'b0, mx} + {1'b0, mn};
      // light half uses 2 - (M + m) as the saturation divisor
      sden  = (sum > 9'd256) ? 9'(10'd512 - {1'b0, sum}) : sum;
      six_d = hpa_pkg::DivWidth'({3'd0, dlt} * 11'd6);
      // hue numerator: sector offset plus the signed channel difference
      if (mx == r_ff) begin
         if (g_ff >= b_ff) begin
            hnum = {3'd0, 8'(g_ff - b_ff)};
         end else begin
            hnum = hpa_pkg::DivWidth'(six_d - {3'd0, 8'(b_ff - g_ff)});
         end
      end else if (mx == g_ff) begin
         hnum = hpa_pkg::DivWidth'({2'd0, dlt, 1'b0} + {3'd0, b_ff} - {3'd0, r_ff});
      end else begin
         hnum = hpa_pkg::DivWidth'({1'd0, dlt, 2'b0} + {3'd0, r_ff} - {3'd0, g_ff});
      end
   end

   logic [hpa_pkg::DivWidth-1:0] snum_ff, sden_ff, hnum_ff, hden_ff;
   logic [15:0]                  lb_ff;
   logic                         greyb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         snum_ff  <= {3'd0, dlt};
         sden_ff  <= {2'd0, sden};
         hnum_ff  <= hnum;
         hden_ff  <= six_d;
         lb_ff    <= {sum, 7'd0};
         greyb_ff <= (dlt == '0);
      end
   end

   // dividers, with lightness and the grey flag carried alongside
   logic [hpa_pkg::QuoWidth-1:0] s_quo, h_quo;

   hpa_div u_div_sat (
      .clock (clock),
      .adv   (adv),
      .num   (snum_ff),
      .den   (sden_ff),
      .quo   (s_quo)
   );

   hpa_div u_div_hue (
      .clock (clock),
      .adv   (adv),
      .num   (hnum_ff),
      .den   (hden_ff),
      .quo   (h_quo)
   );

   logic [15:0] l_pipe_ff    [hpa_pkg::DivStages];
   logic        grey_pipe_ff [hpa_pkg::DivStages];

   always_ff @(posedge clock) begin
      if (adv) begin
         l_pipe_ff[0]    <= lb_ff;
         grey_pipe_ff[0] <= greyb_ff;
         for (int i = 1; i < hpa_pkg::DivStages; i++) begin
            l_pipe_ff[i]    <= l_pipe_ff[i-1];
            grey_pipe_ff[i] <= grey_pipe_ff[i-1];
         end
      end
   end

   // stage C: add offsets and clamp to 0 .. 0.99
   function automatic logic [15:0] clamp_comp(logic signed [18:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > $signed({3'd0, hpa_pkg::CompMax})) begin
         return hpa_pkg::CompMax;
      end else begin
         return v[15:0];
      end
   endfunction

   logic [hpa_pkg::QuoWidth-1:0] h_raw, s_raw;
   logic [15:0]                  l_raw;
   logic signed [18:0]           h_sum, s_sum, l_sum;
   logic [15:0]                  hc_ff, sc_ff, lc_ff;

   always_comb begin
      // grey pixel: drop the divider results (hue divisor was zero)
      h_raw = grey_pipe_ff[hpa_pkg::DivStages-1] ? '0 : h_quo;
      s_raw = grey_pipe_ff[hpa_pkg::DivStages-1] ? '0 : s_quo;
      l_raw = l_pipe_ff[hpa_pkg::DivStages-1];
      h_sum = $signed({2'd0, h_raw}) + $signed({offsets.hue[17], offsets.hue});
      s_sum = $signed({2'd0, s_raw}) + $signed({offsets.sat[17], offsets.sat});
      l_sum = $signed({3'd0, l_raw}) + $signed({offsets.lit[17], offsets.lit});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hc_ff <= clamp_comp(h_sum);
         sc_ff <= clamp_comp(s_sum);
         lc_ff <= clamp_comp(l_sum);
      end
   end

   // back to RGB; the output register sits at the end of this unit
   hpa_back u_back (
      .clock (clock),
      .adv   (adv),
      .hue   (hc_ff),
      .sat   (sc_ff),
      .lit   (lc_ff),
      .red   (rsp_chan.red_out),
      .green (rsp_chan.green_out),
      .blue  (rsp_chan.blue_out)
   );

   assign rsp_chan.valid = vld_ff[NumStages-1];

   // an item one stage from the end reaches the output on the next advance
   a_last_reaches_out: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[NumStages-2] |=> rsp_chan.valid)
      else $error("item lost before the output stage");

   // a stalled output freezes every stage
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> $stable(vld_ff))
      else $error("pipeline moved during an output stall");

   // clamped components stay inside 0 .. 0.99
   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[StC] |-> (hc_ff <= hpa_pkg::CompMax) && (sc_ff <= hpa_pkg::CompMax)
                      && (lc_ff <= hpa_pkg::CompMax))
      else $error("component beyond clamp limit");

endmodule

// ===== src/hpa_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hpa_csr: offset registers
// Scale degree and percent offsets to signed Q0.16 on write and hold them.
// ---------------------------------------------------------------------------
module hpa_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [9:0]         csr_data,
   output hpa_pkg::offsets_type offsets
);

   typedef logic [12:0] hue_tab_type [45];
   typedef logic [13:0] pct_tab_type [25];

   // round(b * 65536 / 360) for b < 45, i.e. b * 8192 / 45
   function automatic hue_tab_type hue_tab_init();
      hue_tab_type t;
      for (int i = 0; i < 45; i++) begin
         t[i] = 13'((i * 16384 + 45) / 90);
      end
      return t;
   endfunction

   // round(b * 65536 / 100) for b < 25, i.e. b * 16384 / 25
   function automatic pct_tab_type pct_tab_init();
      pct_tab_type t;
      for (int i = 0; i < 25; i++) begin
         t[i] = 14'((i * 32768 + 25) / 50);
      end
      return t;
   endfunction

   localparam hue_tab_type HueTab = hue_tab_init();
   localparam pct_tab_type PctTab = pct_tab_init();

   // mag = 45a + b; a from a reciprocal multiply, exact for mag <= 512
   function automatic logic signed [hpa_pkg::OffWidth-1:0] hue_scale(logic [9:0] v);
      logic [9:0]  mag;
      logic [20:0] prod;
      logic [3:0]  a;
      logic [5:0]  b;
      logic [16:0] mag_q;
      mag   = v[9] ? 10'(~v + 10'd1) : v;
      prod  = {11'd0, mag} * 21'd1457;
      a     = prod[19:16];
      b     = 6'(mag - 10'({6'd0, a} * 10'd45));
      mag_q = {a, 13'd0} + {4'd0, HueTab[b]};
      return v[9] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
   endfunction

   // mag = 25a + b; exact for mag <= 128
   function automatic logic signed [hpa_pkg::OffWidth-1:0] pct_scale(logic [7:0] v);
      logic [7:0]  mag;
      logic [19:0] prod;
      logic [2:0]  a;
      logic [4:0]  b;
      logic [16:0] mag_q;
      mag   = v[7] ? 8'(~v + 8'd1) : v;
      prod  = {12'd0, mag} * 20'd2622;
      a     = prod[18:16];
      b     = 5'(mag - 8'({5'd0, a} * 8'd25));
      mag_q = {a, 14'd0} + {3'd0, PctTab[b]};
      return v[7] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
   endfunction

   hpa_pkg::offsets_type offs_ff, offs_in;

   always_comb begin
      offs_in = offs_ff;
      if (csr_write_en) begin
         case (csr_index)
            hpa_pkg::CSR_HUE: offs_in.hue = hue_scale(csr_data);
            hpa_pkg::CSR_SAT: offs_in.sat = pct_scale(csr_data[7:0]);
            hpa_pkg::CSR_LIT: offs_in.lit = pct_scale(csr_data[7:0]);
            default:          offs_in = offs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offs_ff <= '0;
      end else begin
         offs_ff <= offs_in;
      end
   end

   assign offsets = offs_ff;

endmodule

// ===== src/hpa_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hpa_div: pipelined fraction divider
// floor(num * 2^16 / den) for num <= den, restoring, four bits per stage.
// ---------------------------------------------------------------------------
module hpa_div (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [hpa_pkg::DivWidth-1:0]  num,
   input  logic [hpa_pkg::DivWidth-1:0]  den,
   output logic [hpa_pkg::QuoWidth-1:0]  quo
);

   localparam int Last = hpa_pkg::DivStages - 1;

   logic [hpa_pkg::DivWidth-1:0] rem_ff [Last];
   logic [hpa_pkg::DivWidth-1:0] den_ff [Last];
   logic [hpa_pkg::QuoWidth-1:0] quo_ff [hpa_pkg::DivStages];

   // integer bit
   logic                         int_bit;
   logic [hpa_pkg::DivWidth-1:0] rem0_in;

   assign int_bit = (num >= den);
   assign rem0_in = int_bit ? hpa_pkg::DivWidth'(num - den) : num;

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem0_in;
         den_ff[0] <= den;
         quo_ff[0] <= {int_bit, hpa_pkg::FracBits'(0)};
      end
   end

   for (genvar k = 1; k < hpa_pkg::DivStages; k++) begin : g_stage
      logic [hpa_pkg::DivWidth-1:0] rem_in;
      logic [hpa_pkg::QuoWidth-1:0] quo_in;

      always_comb begin
         logic [hpa_pkg::DivWidth:0] part;
         rem_in = rem_ff[k-1];
         quo_in = quo_ff[k-1];
         for (int j = 0; j < hpa_pkg::DivFracPerStage; j++) begin
            part = {rem_in, 1'b0};
            if (part >= {1'b0, den_ff[k-1]}) begin
               quo_in[hpa_pkg::FracBits - (k-1) * hpa_pkg::DivFracPerStage - 1 - j] = 1'b1;
               rem_in = hpa_pkg::DivWidth'(part - {1'b0, den_ff[k-1]});
            end else begin
               rem_in = part[hpa_pkg::DivWidth-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < Last) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign quo = quo_ff[Last];

endmodule

// ===== src/hpa_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hpa_back: HSL to RGB
// Four stages: l*s product, q/p and band select, band product, channel out.
// ---------------------------------------------------------------------------
module hpa_back (
   input  logic        clock,
   input  logic        adv,
   input  logic [15:0] hue,
   input  logic [15:0] sat,
   input  logic [15:0] lit,
   output logic [7:0]  red,
   output logic [7:0]  green,
   output logic [7:0]  blue
);

   typedef enum logic [1:0] {
      BAND_RISE,
      BAND_PEAK,
      BAND_FALL,
      BAND_LOW
   } band_type;

   // first t outside each band
   localparam logic [15:0] RiseEnd = 16'd10923;
   localparam logic [15:0] PeakEnd = 16'd32768;
   localparam logic [15:0] FallEnd = 16'd43691;

   // stage 1: l*s
   logic [15:0] h1_ff, s1_ff, l1_ff, ls1_ff;
   logic        zero1_ff;
   logic [31:0] ls_prod;

   assign ls_prod = {16'd0, lit} * {16'd0, sat};

   always_ff @(posedge clock) begin
      if (adv) begin
         h1_ff    <= hue;
         s1_ff    <= sat;
         l1_ff    <= lit;
         ls1_ff   <= ls_prod[31:16];
         zero1_ff <= (sat == '0);
      end
   end

   // stage 2: q, p and band of each channel
   logic [15:0] q_in, p_in;
   logic [15:0] t_in [3];
   band_type    code_in [3];
   logic [16:0] fac_in [3];

   logic [15:0] q2_ff, p2_ff, diff2_ff, l2_ff;
   logic        zero2_ff;
   band_type    code2_ff [3];
   logic [16:0] fac2_ff [3];

   always_comb begin
      logic [18:0] six_t;
      if (l1_ff < PeakEnd) begin
         q_in = 16'(l1_ff + ls1_ff);
      end else begin
         q_in = 16'(l1_ff + s1_ff - ls1_ff);
      end
      p_in = 16'({l1_ff, 1'b0} - {1'b0, q_in});
      t_in[0] = 16'(h1_ff + hpa_pkg::Third);
      t_in[1] = h1_ff;
      t_in[2] = 16'(h1_ff - hpa_pkg::Third);
      for (int c = 0; c < 3; c++) begin
         six_t = 19'({3'd0, t_in[c]} * 19'd6);
         if (t_in[c] < RiseEnd) begin
            code_in[c] = BAND_RISE;
            fac_in[c]  = six_t[16:0];
         end else if (t_in[c] < PeakEnd) begin
            code_in[c] = BAND_PEAK;
            fac_in[c]  = '0;
         end else if (t_in[c] < FallEnd) begin
            code_in[c] = BAND_FALL;
            fac_in[c]  = 17'(19'd262144 - six_t);
         end else begin
            code_in[c] = BAND_LOW;
            fac_in[c]  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q2_ff    <= q_in;
         p2_ff    <= p_in;
         diff2_ff <= 16'(q_in - p_in);
         l2_ff    <= l1_ff;
         zero2_ff <= zero1_ff;
         code2_ff <= code_in;
         fac2_ff  <= fac_in;
      end
   end

   // stage 3: (q - p) * factor
   logic [32:0] prod_w [3];
   logic [15:0] q3_ff, p3_ff, l3_ff;
   logic        zero3_ff;
   band_type    code3_ff [3];
   logic [15:0] pr3_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_w[c] = {17'd0, diff2_ff} * {16'd0, fac2_ff[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q3_ff    <= q2_ff;
         p3_ff    <= p2_ff;
         l3_ff    <= l2_ff;
         zero3_ff <= zero2_ff;
         code3_ff <= code2_ff;
         for (int c = 0; c < 3; c++) begin
            pr3_ff[c] <= prod_w[c][31:16];
         end
      end
   end

   // stage 4: channel value
   logic [7:0]  chan_in [3];
   logic [7:0]  chan_ff [3];

   always_comb begin
      logic [15:0] v;
      for (int c = 0; c < 3; c++) begin
         case (code3_ff[c])
            BAND_RISE: v = 16'(p3_ff + pr3_ff[c]);
            BAND_FALL: v = 16'(p3_ff + pr3_ff[c]);
            BAND_PEAK: v = q3_ff;
            BAND_LOW:  v = p3_ff;
            default:   v = p3_ff;
         endcase
         chan_in[c] = zero3_ff ? l3_ff[15:8] : v[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         chan_ff <= chan_in;
      end
   end

   assign red   = chan_ff[0];
   assign green = chan_ff[1];
   assign blue  = chan_ff[2];

endmodule
